### src/led_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_pkg
// Shared types and constants for the line edit discipline block.
// ----------------------------------------------------------------------------
package led_pkg;

    localparam int BYTE_W = 8;
    localparam int CHAR_W = 7;
    localparam int LEN_W  = 6;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;

    // register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_ERASE = 2'd0;
    localparam logic [1:0] REG_KILL  = 2'd1;
    localparam logic [1:0] REG_WERASE = 2'd2;
    localparam logic [1:0] REG_END   = 2'd3;

    localparam logic [BYTE_W-1:0] RST_ERASE  = 8'd127;
    localparam logic [BYTE_W-1:0] RST_KILL   = 8'd21;
    localparam logic [BYTE_W-1:0] RST_WERASE = 8'd23;
    localparam logic [BYTE_W-1:0] RST_END    = 8'd4;

    typedef enum logic [2:0] {
        ACT_ECHO         = 3'd0,
        ACT_RUBOUT       = 3'd1,
        ACT_NEWLINE_ECHO = 3'd2,
        ACT_BELL         = 3'd3,
        ACT_END          = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_ERASE,
        CLS_KILL,
        CLS_WERASE,
        CLS_PRINT,
        CLS_BELL
    } t_class;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERASE,
        OP_KILL,
        OP_CLR,
        OP_STORE,
        OP_POP
    } t_op;

    typedef struct packed {
        logic [BYTE_W-1:0] erase_code;
        logic [BYTE_W-1:0] kill_code;
        logic [BYTE_W-1:0] word_erase_code;
        logic [BYTE_W-1:0] end_code;
    } t_codes;

    typedef struct packed {
        t_op     op;
        logic    rd_last;   // read entry at len-1
        logic    rd_next;   // read entry at len-2 (paired with a pop)
        logic    out_load;
        t_action action;
    } t_cmd;

    typedef struct packed {
        t_class cls;
        logic   len_zero;
        logic   len_one;
        logic   full;
        logic   is_space;
        logic   out_free;
    } t_stat;

endpackage
`default_nettype wire

### src/led_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module led_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### src/led_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_ctrl
// Sequencer: accepts one byte, decodes it, walks the word erase scan and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module led_ctrl
    import led_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WSPACE,
        S_WWORD,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_action r_act, n_act;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_act         = r_act;
        o_cmd.op      = OP_NONE;
        o_cmd.rd_last = 1'b0;
        o_cmd.rd_next = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.action  = r_act;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.cls)
                    CLS_END: begin
                        o_cmd.op = OP_CLR;
                        n_act    = ACT_END;
                    end
                    CLS_ERASE: begin
                        o_cmd.op = OP_ERASE;
                        n_act    = ACT_RUBOUT;
                    end
                    CLS_KILL: begin
                        o_cmd.op = OP_KILL;
                        n_act    = ACT_RUBOUT;
                    end
                    CLS_WERASE: begin
                        o_cmd.op = OP_CLR;
                        n_act    = ACT_RUBOUT;
                        if (!i_stat.len_zero) begin
                            o_cmd.rd_last = 1'b1;
                            n_state       = S_WSPACE;
                        end
                    end
                    CLS_PRINT: begin
                        o_cmd.op = OP_STORE;
                        n_act    = i_stat.full ? ACT_NEWLINE_ECHO : ACT_ECHO;
                    end
                    default: begin
                        o_cmd.op = OP_CLR;
                        n_act    = ACT_BELL;
                    end
                endcase
            end
            S_WSPACE: begin
                // every char here is removed; a non-space starts the word phase
                o_cmd.op = OP_POP;
                if (i_stat.len_one) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    if (!i_stat.is_space) begin
                        n_state = S_WWORD;
                    end
                end
            end
            S_WWORD: begin
                if (i_stat.is_space) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_POP;
                    if (i_stat.len_one) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_ECHO;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

endmodule
`default_nettype wire

### src/led_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_dp
// Datapath: byte register, line length, rubout counter, line store and
// output register.
// ----------------------------------------------------------------------------
module led_dp
    import led_pkg::*;
#(
    parameter int LINE_WIDTH = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_codes            i_codes,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [2:0]             o_out_action,
    output logic [BYTE_W-1:0]      o_out_echo,
    output logic [LEN_W-1:0]       o_out_rub
);

    localparam int AW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_WIDTH);

    logic [BYTE_W-1:0] r_byte;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_rub, n_rub;
    logic              r_out_valid;
    t_action           r_out_action;
    logic [BYTE_W-1:0] r_out_echo;
    logic [LEN_W-1:0]  r_out_rub;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [LEN_W-1:0]  rd_idx;
    logic [CHAR_W-1:0] rd_data;
    logic              full;
    t_class            cls;

    assign full = (r_len >= LEN_MAX);

    // byte class, in priority order
    always_comb begin
        if (r_byte == i_codes.end_code && r_len == '0) begin
            cls = CLS_END;
        end else if (r_byte == i_codes.erase_code) begin
            cls = CLS_ERASE;
        end else if (r_byte == i_codes.kill_code) begin
            cls = CLS_KILL;
        end else if (r_byte == i_codes.word_erase_code) begin
            cls = CLS_WERASE;
        end else if (r_byte >= PRINT_LO && r_byte <= PRINT_HI) begin
            cls = CLS_PRINT;
        end else begin
            cls = CLS_BELL;
        end
    end

    assign o_stat.cls      = cls;
    assign o_stat.len_zero = (r_len == '0);
    assign o_stat.len_one  = (r_len == LEN_W'(1));
    assign o_stat.full     = full;
    assign o_stat.is_space = (rd_data == CHAR_SPACE);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_len   = r_len;
        n_rub   = r_rub;
        wr_en   = 1'b0;
        wr_addr = r_len[AW-1:0];
        case (i_cmd.op)
            OP_ERASE: begin
                if (r_len != '0) begin
                    n_len = r_len - LEN_W'(1);
                    n_rub = LEN_W'(1);
                end else begin
                    n_rub = '0;
                end
            end
            OP_KILL: begin
                n_rub = r_len;
                n_len = '0;
            end
            OP_CLR: begin
                n_rub = '0;
            end
            OP_STORE: begin
                n_rub = '0;
                wr_en = 1'b1;
                if (full) begin
                    wr_addr = '0;
                    n_len   = LEN_W'(1);
                end else begin
                    n_len = r_len + LEN_W'(1);
                end
            end
            OP_POP: begin
                n_len = r_len - LEN_W'(1);
                n_rub = r_rub + LEN_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign rd_idx = i_cmd.rd_next ? (r_len - LEN_W'(2)) : (r_len - LEN_W'(1));

    led_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_WIDTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_byte[CHAR_W-1:0]),
        .i_rd_en   (i_cmd.rd_last || i_cmd.rd_next),
        .i_rd_addr (rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_byte <= i_in_byte;
        end
        r_rub <= n_rub;
        if (i_cmd.out_load) begin
            r_out_action <= i_cmd.action;
            r_out_rub    <= r_rub;
            if (i_cmd.action == ACT_ECHO || i_cmd.action == ACT_NEWLINE_ECHO) begin
                r_out_echo <= r_byte;
            end else begin
                r_out_echo <= '0;
            end
        end
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_action = r_out_action;
    assign o_out_echo   = r_out_echo;
    assign o_out_rub    = r_out_rub;

endmodule
`default_nettype wire

### src/line_edit_discipline.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_edit_discipline
// Canonical line editor: one keyboard byte in, one terminal action out.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake              payload
//  ---------  ---  ---------------------  -----------------------------------
//  s_axis     in   tvalid / tready        tdata[7:0] in_byte
//  m_axis     out  tvalid / tready        tdata: action, echo_byte, rubout
//  apb        in   psel, penable, pready  4 code registers at 0x0..0xC
//
//  Steps: a byte holds the sequencer through accept, decode and result
//  load; its result is then registered in the output register. A word
//  erase inserts its scan (space phase, then word phase) between decode
//  and result load, reading the line store through its one read port.
//  A byte is accepted only while the sequencer is idle; a finished result
//  sits in the output register, so the next byte can be taken and worked
//  on while the result waits. A stalled output holds the sequencer in its
//  last step until the register frees.
//  Reset clears the line length and the output valid; the line store is
//  not cleared (only entries below the length are ever read).
//
// ----------------------------------------------------------------------------
module line_edit_discipline
    import led_pkg::*;
#(
    parameter int LINE_WIDTH = 40
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // keyboard beats
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    // terminal action beats
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [2:0] action, [10:3] echo_byte,
                                               // [16:11] rubout_count, rest zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_codes            r_codes;
    t_cmd              cmd;
    t_stat             stat;
    logic [2:0]        out_action;
    logic [BYTE_W-1:0] out_echo;
    logic [LEN_W-1:0]  out_rub;
    logic [1:0]        reg_idx;

    // register index is the word address; byte offset bits are ignored
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.erase_code      <= RST_ERASE;
            r_codes.kill_code       <= RST_KILL;
            r_codes.word_erase_code <= RST_WERASE;
            r_codes.end_code        <= RST_END;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_ERASE:  r_codes.erase_code      <= pwdata[BYTE_W-1:0];
                REG_KILL:   r_codes.kill_code       <= pwdata[BYTE_W-1:0];
                REG_WERASE: r_codes.word_erase_code <= pwdata[BYTE_W-1:0];
                REG_END:    r_codes.end_code        <= pwdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ERASE:  prdata = {24'd0, r_codes.erase_code};
            REG_KILL:   prdata = {24'd0, r_codes.kill_code};
            REG_WERASE: prdata = {24'd0, r_codes.word_erase_code};
            REG_END:    prdata = {24'd0, r_codes.end_code};
            default:    prdata = '0;
        endcase
    end

    // sequencer
    led_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // length, counters, line store, output register
    led_dp #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_codes      (r_codes),
        .i_in_byte    (i_s_axis_tdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_action (out_action),
        .o_out_echo   (out_echo),
        .o_out_rub    (out_rub)
    );

    assign o_m_axis_tdata = {7'd0, out_rub, out_echo, out_action};

endmodule
`default_nettype wire
